FILE: design/block_average_with_error_unit_macros.svh
`ifndef BLOCK_AVERAGE_WITH_ERROR_UNIT_MACROS_SVH
`define BLOCK_AVERAGE_WITH_ERROR_UNIT_MACROS_SVH
// Same-cycle implication, checked on every clock once out of reset
`define BAWE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bawe check failed");
// Next-cycle implication
`define BAWE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bawe check failed");
`endif

FILE: design/bawe_pkg.sv
package bawe_pkg;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BLOCKS  = 1024;
    localparam int SUM_BITS    = 48;
    localparam int NUM_BITS    = SUM_BITS + 1;
    localparam int DEN_BITS    = 16;
    localparam int MUL_BITS    = 31;
    localparam int SQ_BITS     = 38;
    localparam int SQRT_STEPS  = 32;
    localparam int CNT_BITS    = 6;
    localparam logic [SAMPLE_BITS-1:0] HALF_SAMPLE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
    localparam logic [1:0] REG_BLOCK_COUNT  = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVE_DIV,
        ST_AVE_SQ,
        ST_MEAN_DIV,
        ST_MSQ_DIV,
        ST_M2_SQ,
        ST_V_DIV,
        ST_SQRT,
        ST_OUT
    } state_t;
endpackage

FILE: design/block_average_with_error_unit.sv
// Block averaging unit: mean and statistical error of (x-0.5)^2 over blocks.
// s_ channel: one sample per transaction (unsigned Q0.16). Samples are taken one
// per cycle while a block fills. The sample that closes a block starts the
// end-of-block sequence, which runs through one shared bit-serial divider, a
// shift-add squarer and a bit-pair square root. s_tready is low during that
// sequence and during the wait for the output register; the result appears
// as the sequence ends.
// m_ channel: one transaction per closed block; tlast marks the run's final
// block, after which all sums clear. The result waits in the output register
// while m_tready is low; a new block can fill meanwhile, and the next result
// is held back until that register frees.
// cfg port: write enable, index (0 block_length, 1 block_count), data.
// Reset (aresetn low, synchronous) restores block_length 1000, block_count
// 100, clears all sums and counts and empties the output.
module block_average_with_error_unit
    import bawe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [10:0] block_number, [41:11] running_mean,
                                   // [71:42] std_error
    output logic        m_tlast
);

    state_t state_reg, state_next;

    logic [15:0]          block_length_reg;
    logic [10:0]          block_count_reg;
    logic [SUM_BITS-1:0]  block_sum_reg, average_sum_reg, average_square_sum_reg;
    logic [15:0]          samples_seen_reg;
    logic [10:0]          blocks_done_reg, n_reg;
    logic [CNT_BITS-1:0]  step_cnt_reg;

    logic [NUM_BITS-1:0]  div_q_reg;
    logic [DEN_BITS-1:0]  div_rem_reg, div_den_reg;
    logic [2*MUL_BITS-1:0] mul_prod_reg;
    logic [MUL_BITS-1:0]  mul_cand_reg;
    logic [63:0]          sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [MUL_BITS-1:0]  mean_reg;
    logic [NUM_BITS-1:0]  msq_reg;
    logic [29:0]          err_reg;

    logic                 m_tvalid_reg, m_tlast_reg;
    logic [71:0]          m_tdata_reg;

    // sample path
    logic [15:0]         dev;
    logic [31:0]         dev_sq;
    logic [SUM_BITS-1:0] block_sum_new;
    logic [15:0]         len_eff;
    logic [10:0]         cnt_eff;
    logic                block_close, accept;

    // serial units
    logic [16:0]         div_trial, div_diff;
    logic                div_ge;
    logic [NUM_BITS-1:0] div_q_final;
    logic [31:0]         mul_sum;
    logic [2*MUL_BITS-1:0] mul_prod_next;
    logic [2*MUL_BITS:0] mul_round;
    logic [SQ_BITS-1:0]  mul_sq;
    logic [63:0]         sq_trial;
    logic                sq_ge;
    logic                div_done, mul_done, sqrt_done, out_free;

    logic [NUM_BITS-1:0] var_val, v_clamped;
    logic [10:0]         n_minus1;
    logic                is_last;

    assign dev = (s_tdata >= HALF_SAMPLE) ? s_tdata - HALF_SAMPLE : HALF_SAMPLE - s_tdata;
    assign dev_sq = dev * dev;
    assign block_sum_new = block_sum_reg + SUM_BITS'(dev_sq);
    assign len_eff = (block_length_reg == 16'd0) ? 16'd1 : block_length_reg;
    always_comb begin
        if (block_count_reg == 11'd0) begin
            cnt_eff = 11'd1;
        end else if (block_count_reg > 11'(MAX_BLOCKS)) begin
            cnt_eff = 11'(MAX_BLOCKS);
        end else begin
            cnt_eff = block_count_reg;
        end
    end
    assign block_close = !(({1'b0, samples_seen_reg} + 17'd1) < {1'b0, len_eff});
    assign accept = s_tvalid && s_tready;

    assign div_trial   = {div_rem_reg, div_q_reg[NUM_BITS-1]};
    assign div_ge      = div_trial >= {1'b0, div_den_reg};
    assign div_diff    = div_ge ? div_trial - {1'b0, div_den_reg} : div_trial;
    assign div_q_final = {div_q_reg[NUM_BITS-2:0], div_ge};
    assign mul_sum     = {1'b0, mul_prod_reg[2*MUL_BITS-1:MUL_BITS]}
                       + (mul_prod_reg[0] ? {1'b0, mul_cand_reg} : 32'd0);
    assign mul_prod_next = {mul_sum, mul_prod_reg[MUL_BITS-1:1]};
    // round the product as its last step completes
    assign mul_round = {1'b0, mul_prod_next} + ((2*MUL_BITS+1)'(1) << 23);
    assign mul_sq    = mul_round[SQ_BITS+23:24];
    assign sq_trial  = sq_res_reg + sq_bit_reg;
    assign sq_ge     = sq_v_reg >= sq_trial;

    assign div_done  = step_cnt_reg == CNT_BITS'(NUM_BITS - 1);
    assign mul_done  = step_cnt_reg == CNT_BITS'(MUL_BITS - 1);
    assign sqrt_done = step_cnt_reg == CNT_BITS'(SQRT_STEPS - 1);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign var_val   = (msq_reg > NUM_BITS'(mul_sq)) ? msq_reg - NUM_BITS'(mul_sq) : '0;
    assign v_clamped = (div_q_final > (NUM_BITS'(1) << 38)) ? (NUM_BITS'(1) << 38)
                                                            : div_q_final;
    assign n_minus1  = n_reg - 11'd1;
    assign is_last   = n_reg >= cnt_eff;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept && block_close) state_next = ST_AVE_DIV;
            ST_AVE_DIV:  if (div_done) state_next = ST_AVE_SQ;
            ST_AVE_SQ:   if (mul_done) state_next = ST_MEAN_DIV;
            ST_MEAN_DIV: if (div_done) state_next = (n_reg == 11'd1) ? ST_OUT : ST_MSQ_DIV;
            ST_MSQ_DIV:  if (div_done) state_next = ST_M2_SQ;
            ST_M2_SQ:    if (mul_done) state_next = ST_V_DIV;
            ST_V_DIV:    if (div_done) state_next = ST_SQRT;
            ST_SQRT:     if (sqrt_done) state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = state_reg == ST_IDLE;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg              <= ST_IDLE;
            block_length_reg       <= 16'd1000;
            block_count_reg        <= 11'd100;
            block_sum_reg          <= '0;
            samples_seen_reg       <= '0;
            blocks_done_reg        <= '0;
            average_sum_reg        <= '0;
            average_square_sum_reg <= '0;
            step_cnt_reg           <= '0;
            m_tvalid_reg           <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && cfg_addr == REG_BLOCK_LENGTH) block_length_reg <= cfg_wr_data;
            if (cfg_wr_en && cfg_addr == REG_BLOCK_COUNT) block_count_reg <= cfg_wr_data[10:0];
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // restart the step count whenever the sequence moves on
            step_cnt_reg <= (state_next != state_reg) ? '0 : step_cnt_reg + CNT_BITS'(1);
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (block_close) begin
                            block_sum_reg    <= '0;
                            samples_seen_reg <= '0;
                        end else begin
                            block_sum_reg    <= block_sum_new;
                            samples_seen_reg <= samples_seen_reg + 16'd1;
                        end
                    end
                end
                ST_AVE_DIV: begin
                    if (div_done) begin
                        average_sum_reg <= average_sum_reg
                                         + SUM_BITS'(div_q_final[MUL_BITS-1:0]);
                    end
                end
                ST_AVE_SQ: begin
                    if (mul_done) begin
                        average_square_sum_reg <= average_square_sum_reg + SUM_BITS'(mul_sq);
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        if (is_last) begin
                            blocks_done_reg        <= '0;
                            average_sum_reg        <= '0;
                            average_square_sum_reg <= '0;
                        end else begin
                            blocks_done_reg <= n_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath of the serial units and operand loading between steps
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                div_q_reg   <= NUM_BITS'(block_sum_new) + NUM_BITS'(len_eff >> 1);
                div_rem_reg <= '0;
                div_den_reg <= len_eff;
                n_reg       <= blocks_done_reg + 11'd1;
                err_reg     <= '0;
            end
            ST_AVE_DIV, ST_MEAN_DIV, ST_MSQ_DIV, ST_V_DIV: begin
                if (!div_done) begin
                    div_q_reg   <= div_q_final;
                    div_rem_reg <= div_diff[DEN_BITS-1:0];
                end else begin
                    div_rem_reg <= '0;
                    if (state_reg == ST_AVE_DIV) begin
                        mul_prod_reg <= {{MUL_BITS{1'b0}}, div_q_final[MUL_BITS-1:0]};
                        mul_cand_reg <= div_q_final[MUL_BITS-1:0];
                    end else if (state_reg == ST_MEAN_DIV) begin
                        mean_reg  <= div_q_final[MUL_BITS-1:0];
                        div_q_reg <= NUM_BITS'(average_square_sum_reg) + NUM_BITS'(n_reg >> 1);
                    end else if (state_reg == ST_MSQ_DIV) begin
                        msq_reg      <= div_q_final;
                        mul_prod_reg <= {{MUL_BITS{1'b0}}, mean_reg};
                        mul_cand_reg <= mean_reg;
                    end else begin
                        // the variance quotient feeds the root
                        sq_v_reg   <= 64'(v_clamped) << 24;
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'd1 << 62;
                    end
                end
            end
            ST_AVE_SQ, ST_M2_SQ: begin
                mul_prod_reg <= mul_prod_next;
                if (mul_done) begin
                    div_rem_reg <= '0;
                    if (state_reg == ST_AVE_SQ) begin
                        div_q_reg   <= NUM_BITS'(average_sum_reg) + NUM_BITS'(n_reg >> 1);
                        div_den_reg <= DEN_BITS'(n_reg);
                    end else begin
                        div_q_reg   <= var_val + NUM_BITS'(n_minus1 >> 1);
                        div_den_reg <= DEN_BITS'(n_minus1);
                    end
                end
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    sq_v_reg   <= sq_v_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                if (sqrt_done) begin
                    if (sq_ge) begin
                        err_reg <= (((sq_res_reg >> 1) + sq_bit_reg) > 64'h3FFF_FFFF)
                                 ? 30'h3FFF_FFFF : sq_res_reg[30:1] + sq_bit_reg[29:0];
                    end else begin
                        err_reg <= ((sq_res_reg >> 1) > 64'h3FFF_FFFF)
                                 ? 30'h3FFF_FFFF : sq_res_reg[30:1];
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {err_reg, mean_reg, n_reg};
                    m_tlast_reg <= is_last;
                end
            end
            default: ;
        endcase
    end

    `include "block_average_with_error_unit_macros.svh"

    `BAWE_ASSERT_NOW(a_busy_blocks_input, state_reg != ST_IDLE, !s_tready)
    `BAWE_ASSERT_NEXT(a_held_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BAWE_ASSERT_NEXT(a_run_clears, m_tvalid && m_tready && m_tlast && state_reg != ST_OUT,
                      blocks_done_reg == 11'd0 || m_tvalid)
    `BAWE_ASSERT_NOW(a_block_number_nonzero, m_tvalid, m_tdata[10:0] != 11'd0)
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import bawe_pkg::*;
();

    typedef struct packed {
        logic [10:0] blk;
        logic [30:0] mean;
        logic [29:0] err;
        logic        last;
    } block_stat_t;

    // Blocking-method statistics tracker with its own copy of the state.
    class block_stat_board;
        logic [15:0] len_reg;
        logic [10:0] cnt_reg;
        logic [47:0] acc_sq;
        logic [15:0] seen;
        logic [10:0] nblk;
        logic [47:0] sum_ave;
        logic [47:0] sum_ave_sq;
        block_stat_t pending[$];
        int unsigned n_bad;
        int unsigned n_got;

        function new();
            len_reg = 16'd1000;
            cnt_reg = 11'd100;
            acc_sq = '0;
            seen = '0;
            nblk = '0;
            sum_ave = '0;
            sum_ave_sq = '0;
            n_bad = 0;
            n_got = 0;
        endfunction

        function logic [63:0] rdiv(logic [63:0] num, logic [63:0] den);
            if (den == 0) return 64'd0;
            return (num + den / 2) / den;
        endfunction

        function logic [63:0] sq40(logic [63:0] q32);
            logic [63:0] p;
            p = q32 * q32;
            return (p + 64'd8388608) >> 24;
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == REG_BLOCK_LENGTH) len_reg = val;
            else if (idx == REG_BLOCK_COUNT) cnt_reg = val[10:0];
        endfunction

        function void note_sample(logic [15:0] x);
            logic [63:0] d, len, cnt, n, ave, mean, err, msq, m2, var_q, v;
            block_stat_t r;
            d = (x >= 16'h8000) ? x - 16'h8000 : 16'h8000 - x;
            len = (len_reg == 0) ? 1 : len_reg;
            cnt = (cnt_reg == 0) ? 1 : cnt_reg;
            if (cnt > MAX_BLOCKS) cnt = MAX_BLOCKS;
            acc_sq = acc_sq + 48'(d * d);
            if (64'(seen) + 1 < len) begin
                seen = seen + 1;
                return;
            end
            ave = rdiv(64'(acc_sq), len);
            acc_sq = '0;
            seen = '0;
            sum_ave = sum_ave + 48'(ave);
            sum_ave_sq = sum_ave_sq + 48'(sq40(ave));
            n = 64'(nblk) + 1;
            mean = rdiv(64'(sum_ave), n);
            err = 0;
            if (n > 1) begin
                msq = rdiv(64'(sum_ave_sq), n);
                m2 = sq40(mean & 64'h7FFF_FFFF);
                var_q = (msq > m2) ? msq - m2 : 0;
                v = rdiv(var_q, n - 1);
                if (v > (64'd1 << 38)) v = 64'd1 << 38;
                err = root(v << 24);
                if (err > 64'h3FFF_FFFF) err = 64'h3FFF_FFFF;
            end
            r.blk = n[10:0];
            r.mean = mean[30:0];
            r.err = err[29:0];
            r.last = (n >= cnt);
            pending.push_back(r);
            if (r.last) begin
                nblk = '0;
                sum_ave = '0;
                sum_ave_sq = '0;
            end else begin
                nblk = n[10:0];
            end
        endfunction

        function void check_result(block_stat_t got);
            block_stat_t exp_r;
            n_got++;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: exp blk %0d mean %h err %h last %b, ",
                             exp_r.blk, exp_r.mean, exp_r.err, exp_r.last,
                             "got blk %0d mean %h err %h last %b",
                             got.blk, got.mean, got.err, got.last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    bit          sink_hold = 1'b0;
    longint unsigned cycles = 0;

    block_stat_board board = new();

    always #4 aclk = ~aclk;

    block_average_with_error_unit uut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3_000_000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Output side: check every result transaction, randomize tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result({m_tdata[10:0], m_tdata[41:11], m_tdata[71:42], m_tlast});
        m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // Leave tvalid high after the transaction; the caller drops it.
    task automatic push_sample(logic [15:0] x);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(x);
    endtask

    // Drain all expected results, then let the end-of-block unit settle.
    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'h8000 + 16'($urandom_range(255));
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic random_phase(int items);
        int mode;
        mode = $urandom_range(2);
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0) mode = $urandom_range(2);
            push_sample(rand_sample(mode));
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, lengths 0 and 1, single-block run, count 0.
        write_cfg(REG_BLOCK_LENGTH, 16'd0);
        write_cfg(REG_BLOCK_COUNT, 16'd3);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h8001);
        push_sample(16'h5555);
        s_tvalid <= 1'b0;
        drain();
        write_cfg(REG_BLOCK_LENGTH, 16'd1);
        push_sample(16'hAAAA);
        push_sample(16'h0000);
        push_sample(16'h8000);
        s_tvalid <= 1'b0;
        drain();
        write_cfg(REG_BLOCK_COUNT, 16'd0);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        s_tvalid <= 1'b0;
        drain();
        // Lower block length mid-block and count mid-run.
        write_cfg(REG_BLOCK_LENGTH, 16'd5);
        write_cfg(REG_BLOCK_COUNT, 16'd1024);
        for (int i = 0; i < 8; i++) push_sample(16'($urandom));
        s_tvalid <= 1'b0;
        drain();
        write_cfg(REG_BLOCK_LENGTH, 16'd2);
        write_cfg(REG_BLOCK_COUNT, 16'd1);
        push_sample(16'h1234);
        s_tvalid <= 1'b0;
        drain();
        write_cfg(REG_BLOCK_COUNT, 16'h7FF);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        s_tvalid <= 1'b0;
        drain();

        // Random phase 1: sender rarely idles, receiver often.
        src_idle_pct = 13;
        sink_idle_pct = 66;
        write_cfg(REG_BLOCK_LENGTH, 16'd3);
        write_cfg(REG_BLOCK_COUNT, 16'd5);
        random_phase(200);
        drain();

        // Long receiver hold-off while samples keep coming.
        src_idle_pct = 0;
        sink_idle_pct = 0;
        write_cfg(REG_BLOCK_LENGTH, 16'd1);
        write_cfg(REG_BLOCK_COUNT, 16'd7);
        fork
            begin
                sink_hold = 1'b1;
                repeat (2000) @(posedge aclk);
                sink_hold = 1'b0;
            end
            random_phase(20);
        join
        drain();

        // Random phase 2: roles swapped; one large block length too.
        src_idle_pct = 66;
        sink_idle_pct = 13;
        write_cfg(REG_BLOCK_LENGTH, 16'd4);
        write_cfg(REG_BLOCK_COUNT, 16'd12);
        random_phase(150);
        drain();
        write_cfg(REG_BLOCK_LENGTH, 16'd60);
        write_cfg(REG_BLOCK_COUNT, 16'd2);
        src_idle_pct = 0;
        random_phase(60 * 2);
        drain();

        // Random phase 3: no idling, many configurations.
        src_idle_pct = 0;
        sink_idle_pct = 0;
        for (int k = 0; k < 6; k++) begin
            write_cfg(REG_BLOCK_LENGTH, 16'($urandom_range(1, 6)));
            write_cfg(REG_BLOCK_COUNT, 16'($urandom_range(1, 20)));
            random_phase(50);
            drain();
        end

        if (board.n_bad == 0 && board.pending.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/bawe_pkg.sv
design/block_average_with_error_unit.sv
sim/tb_top.sv
